// ===== hw/rtl/vic_pkg.sv =====
// vic_pkg: shared types and constants of the vectored interrupt controller
// register map word indexes, item function codes and the encoder result struct
// no dependencies
package vic_pkg;

  localparam int DATA_W  = 32;
  localparam int WORD_W  = 7;
  localparam int SRC_W   = 5;
  localparam int MAX_SRC = 32;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RAISE = 2'd2,
    FUNC_LOWER = 2'd3
  } func_t;

  // register map, word indexes
  localparam logic [WORD_W-1:0] W_IVR  = 7'd64;
  localparam logic [WORD_W-1:0] W_FVR  = 7'd65;
  localparam logic [WORD_W-1:0] W_ISR  = 7'd66;
  localparam logic [WORD_W-1:0] W_IPR  = 7'd67;
  localparam logic [WORD_W-1:0] W_IMR  = 7'd68;
  localparam logic [WORD_W-1:0] W_CISR = 7'd69;
  localparam logic [WORD_W-1:0] W_IECR = 7'd72;
  localparam logic [WORD_W-1:0] W_IDCR = 7'd73;
  localparam logic [WORD_W-1:0] W_FFER = 7'd80;
  localparam logic [WORD_W-1:0] W_FFDR = 7'd81;
  localparam logic [WORD_W-1:0] W_FFSR = 7'd82;

  // first word of the upper area, which holds the fixed registers and the plain storage words
  localparam int OTHER_BASE = 64;

  typedef struct packed {
    logic             fiq_hit;
    logic             irq_hit;
    logic [SRC_W-1:0] fiq_src;
    logic [SRC_W-1:0] irq_src;
  } enc_t;

endpackage

// ===== hw/rtl/vic_ram.sv =====
// vic_ram: generic single write port, single read port ram with registered read
// no dependencies
module vic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vic_encode.sv =====
// vic_encode: lowest-number-wins priority encoder for the fast and normal lines
// depends on vic_pkg
module vic_encode
  import vic_pkg::*;
#(
  parameter int NUM_SOURCES = 32
) (
  input  logic [DATA_W-1:0] active,
  input  logic [DATA_W-1:0] fast,
  output enc_t              enc
);

  // only implemented sources take part
  localparam logic [DATA_W-1:0] SRC_MASK = {DATA_W{1'b1}} >> (MAX_SRC - NUM_SOURCES);

  logic [DATA_W-1:0] fiq_cand;
  logic [DATA_W-1:0] irq_cand;
  logic [DATA_W-1:0] fiq_one;
  logic [DATA_W-1:0] irq_one;
  logic [SRC_W-1:0]  fiq_idx;
  logic [SRC_W-1:0]  irq_idx;

  // source 0 always goes fast, others go fast when forced
  assign fiq_cand = active & SRC_MASK & (fast | {{(DATA_W-1){1'b0}}, 1'b1});
  assign irq_cand = active & SRC_MASK & ~fast & {{(DATA_W-1){1'b1}}, 1'b0};

  // isolate lowest set bit
  assign fiq_one = fiq_cand & (~fiq_cand + {{(DATA_W-1){1'b0}}, 1'b1});
  assign irq_one = irq_cand & (~irq_cand + {{(DATA_W-1){1'b0}}, 1'b1});

  always_comb begin
    fiq_idx = '0;
    irq_idx = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (fiq_one[i]) begin
        fiq_idx = fiq_idx | SRC_W'(i);
      end
      if (irq_one[i]) begin
        irq_idx = irq_idx | SRC_W'(i);
      end
    end
  end

  always_comb begin
    enc.fiq_hit = |fiq_cand;
    enc.irq_hit = |irq_cand;
    enc.fiq_src = fiq_idx;
    enc.irq_src = irq_idx;
  end

endmodule

// ===== hw/rtl/vectored_interrupt_controller.sv =====
// vectored_interrupt_controller: 32-source interrupt controller with fast and normal lines
// depends on vic_pkg, vic_ram, vic_encode
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_func, in_word_index,        | into block
//          | in_write_data, in_source_id                        |
//  out     | out_valid, out_stall, out_read_data, out_irq_line, | out of block
//          | out_fiq_line, out_access_error                     |
//
// one word in per cycle and one word out per cycle, sustained while out_stall stays low
// each result word passes through the input register, then through the
// decode/update/encode pass into the result register
// the normal vector lands in the cycle after its encode via the second vector ram port
// rst_n is synchronous; all register map state comes out of reset as zero
// a stall on out backs up into the input register and then onto in_stall
module vectored_interrupt_controller
  import vic_pkg::*;
#(
  parameter int NUM_SOURCES = 32,
  parameter int REG_WORDS   = 83
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [WORD_W-1:0] in_word_index,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [SRC_W-1:0]  in_source_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_irq_line,
  output logic              out_fiq_line,
  output logic              out_access_error
);

  // plain storage words share the upper map area with the fixed registers
  localparam int OTH_D     = REG_WORDS - OTHER_BASE;
  localparam int OTH_AW    = $clog2(OTH_D);
  localparam int OTH_SLOTS = 1 << OTH_AW;

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic              s1_vld_r;
  func_t             s1_func_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [SRC_W-1:0]  s1_src_r;

  logic in_fire;
  logic s1_fire;
  logic out_vld_r;

  // the item in the input register moves on when the result register is free
  assign s1_fire  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= func_t'(in_func);
      s1_word_r <= in_word_index;
      s1_data_r <= in_write_data;
      s1_src_r  <= in_source_id;
    end
  end

  // word index held in the input register after this edge; ram reads follow it
  logic [WORD_W-1:0] nx_word;
  assign nx_word = in_fire ? in_word_index : s1_word_r;

  // ---------------------------------------------------------------------------
  // decode
  // ---------------------------------------------------------------------------
  logic in_map;
  logic is_rd;
  logic is_wr;
  logic acc_err;
  logic src_ok;

  assign in_map  = {1'b0, s1_word_r} < 8'(REG_WORDS);
  assign is_rd   = (s1_func_r == FUNC_READ) && in_map;
  assign is_wr   = (s1_func_r == FUNC_WRITE) && in_map;
  assign acc_err = ((s1_func_r == FUNC_READ) || (s1_func_r == FUNC_WRITE)) && !in_map;
  assign src_ok  = {1'b0, s1_src_r} < 6'(NUM_SOURCES);

  // ---------------------------------------------------------------------------
  // control register state
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] modes_r [MAX_SRC];
  logic [DATA_W-1:0] vec0_r;
  logic [DATA_W-1:0] irq_vec_r;
  logic [DATA_W-1:0] fiq_vec_r;
  logic [DATA_W-1:0] cur_r;
  logic [DATA_W-1:0] pend_r;
  logic [DATA_W-1:0] mask_r;
  logic [DATA_W-1:0] fast_r;
  logic [1:0]        cs_r;        // core status: bit 1 normal line, bit 0 fast line

  logic [MAX_SRC-1:0]   vec_vld_r;  // vector entry written since reset
  logic [OTH_SLOTS-1:0] oth_vld_r;  // plain word written since reset

  // ---------------------------------------------------------------------------
  // vector store: two copies so bus reads and winner lookups each get a port
  // ---------------------------------------------------------------------------
  logic              vec_we;
  logic [SRC_W-1:0]  vec_waddr;
  logic [DATA_W-1:0] vec_qa;
  logic [DATA_W-1:0] vec_qb;
  enc_t              enc;

  assign vec_we    = s1_fire && is_wr && (s1_word_r[6:5] == 2'b01);
  assign vec_waddr = s1_word_r[SRC_W-1:0];

  vic_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SRC)
  ) u_vec_ram_a (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (s1_data_r),
    .raddr (nx_word[SRC_W-1:0]),
    .rdata (vec_qa)
  );

  vic_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SRC)
  ) u_vec_ram_b (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (s1_data_r),
    .raddr (enc.irq_src),
    .rdata (vec_qb)
  );

  // port a: read-during-write forward and never-written check
  logic              va_fwd_r;
  logic [DATA_W-1:0] va_fdata_r;
  logic              va_vld_r;
  logic [DATA_W-1:0] vec_a_eff;

  always_ff @(posedge clk) begin
    va_fwd_r   <= vec_we && (vec_waddr == nx_word[SRC_W-1:0]);
    va_fdata_r <= s1_data_r;
    va_vld_r   <= vec_vld_r[nx_word[SRC_W-1:0]];
  end

  assign vec_a_eff = va_fwd_r ? va_fdata_r : (va_vld_r ? vec_qa : '0);

  // port b: normal vector of the last winner, folded into irq_vec_r after its registered read
  logic              vb_pend_r;
  logic              vb_fwd_r;
  logic [DATA_W-1:0] vb_fdata_r;
  logic              vb_vld_r;
  logic [DATA_W-1:0] irq_vec_cur;

  always_ff @(posedge clk) begin
    vb_fwd_r   <= vec_we && (vec_waddr == enc.irq_src);
    vb_fdata_r <= s1_data_r;
    vb_vld_r   <= vec_vld_r[enc.irq_src];
  end

  assign irq_vec_cur = vb_pend_r ?
                       (vb_fwd_r ? vb_fdata_r : (vb_vld_r ? vec_qb : '0)) :
                       irq_vec_r;

  // ---------------------------------------------------------------------------
  // plain storage words
  // ---------------------------------------------------------------------------
  logic              oth_hit;
  logic              oth_we;
  logic [OTH_AW-1:0] oth_waddr;
  logic [OTH_AW-1:0] oth_raddr;
  logic [DATA_W-1:0] oth_q;
  logic              oth_fwd_r;
  logic [DATA_W-1:0] oth_fdata_r;
  logic              oth_rvld_r;
  logic [DATA_W-1:0] oth_eff;

  assign oth_we    = s1_fire && is_wr && oth_hit;
  assign oth_waddr = s1_word_r[OTH_AW-1:0];
  assign oth_raddr = nx_word[OTH_AW-1:0];

  vic_ram #(
    .WIDTH (DATA_W),
    .DEPTH (OTH_SLOTS)
  ) u_oth_ram (
    .clk   (clk),
    .we    (oth_we),
    .waddr (oth_waddr),
    .wdata (s1_data_r),
    .raddr (oth_raddr),
    .rdata (oth_q)
  );

  always_ff @(posedge clk) begin
    oth_fwd_r   <= oth_we && (oth_waddr == oth_raddr);
    oth_fdata_r <= s1_data_r;
    oth_rvld_r  <= oth_vld_r[oth_raddr];
  end

  assign oth_eff = oth_fwd_r ? oth_fdata_r : (oth_rvld_r ? oth_q : '0);

  // ---------------------------------------------------------------------------
  // register writes and source events
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] pend_wr;
  logic [DATA_W-1:0] pend_nxt;
  logic [DATA_W-1:0] mask_nxt;
  logic [DATA_W-1:0] fast_nxt;
  logic [DATA_W-1:0] irq_vec_wr;
  logic [DATA_W-1:0] fiq_vec_wr;
  logic [DATA_W-1:0] cur_wr;
  logic [DATA_W-1:0] vec0_nxt;
  logic [DATA_W-1:0] src_bit;

  assign src_bit = {{(DATA_W-1){1'b0}}, 1'b1} << s1_src_r;

  always_comb begin
    pend_wr    = pend_r;
    mask_nxt   = mask_r;
    fast_nxt   = fast_r;
    irq_vec_wr = irq_vec_cur;
    fiq_vec_wr = fiq_vec_r;
    cur_wr     = cur_r;
    oth_hit    = 1'b0;
    if (s1_word_r[6]) begin
      case (s1_word_r)
        W_IVR:  irq_vec_wr = s1_data_r;
        W_FVR:  fiq_vec_wr = s1_data_r;
        W_ISR:  cur_wr     = s1_data_r;
        W_IPR:  pend_wr    = s1_data_r;
        W_IECR: mask_nxt   = mask_r | s1_data_r;
        W_IDCR: mask_nxt   = mask_r & ~s1_data_r;
        W_FFER: fast_nxt   = fast_r | s1_data_r;
        W_FFDR: fast_nxt   = fast_r & ~s1_data_r;
        // read-only words, and core status which the encode rebuilds anyway
        W_IMR, W_CISR, W_FFSR: ;
        default: oth_hit = 1'b1;
      endcase
    end
    // none of the above applies unless the item is an in-map write
    if (!is_wr) begin
      pend_wr    = pend_r;
      mask_nxt   = mask_r;
      fast_nxt   = fast_r;
      irq_vec_wr = irq_vec_cur;
      fiq_vec_wr = fiq_vec_r;
      cur_wr     = cur_r;
    end
  end

  always_comb begin
    pend_nxt = pend_wr;
    if (src_ok) begin
      case (s1_func_r)
        FUNC_RAISE: pend_nxt = pend_r | src_bit;
        FUNC_LOWER: pend_nxt = pend_r & ~src_bit;
        default:    pend_nxt = pend_wr;
      endcase
    end
  end

  assign vec0_nxt = (vec_we && (vec_waddr == '0)) ? s1_data_r : vec0_r;

  // ---------------------------------------------------------------------------
  // priority encode on the updated state
  // ---------------------------------------------------------------------------
  vic_encode #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_encode (
    .active (pend_nxt & mask_nxt),
    .fast   (fast_nxt),
    .enc    (enc)
  );

  logic [DATA_W-1:0] fiq_vec_nxt;
  logic [DATA_W-1:0] cur_nxt;
  logic [1:0]        cs_nxt;

  assign fiq_vec_nxt = enc.fiq_hit ? vec0_nxt : fiq_vec_wr;
  assign cs_nxt      = {enc.irq_hit, enc.fiq_hit};

  // the fast winner owns the current source; a normal one only when no fast source is pending and enabled
  always_comb begin
    if (enc.fiq_hit) begin
      cur_nxt = DATA_W'(enc.fiq_src);
    end else if (enc.irq_hit) begin
      cur_nxt = DATA_W'(enc.irq_src);
    end else begin
      cur_nxt = cur_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SRC; i++) begin
        modes_r[i] <= '0;
      end
      vec0_r    <= '0;
      irq_vec_r <= '0;
      vb_pend_r <= 1'b0;
      fiq_vec_r <= '0;
      cur_r     <= '0;
      pend_r    <= '0;
      mask_r    <= '0;
      fast_r    <= '0;
      cs_r      <= '0;
      vec_vld_r <= '0;
      oth_vld_r <= '0;
    end else begin
      // pending normal vector is folded in whether or not a word moves
      irq_vec_r <= s1_fire ? irq_vec_wr : irq_vec_cur;
      vb_pend_r <= s1_fire && enc.irq_hit;
      if (s1_fire) begin
        if (is_wr && (s1_word_r[6:5] == 2'b00)) begin
          modes_r[s1_word_r[SRC_W-1:0]] <= s1_data_r;
        end
        vec0_r    <= vec0_nxt;
        fiq_vec_r <= fiq_vec_nxt;
        cur_r     <= cur_nxt;
        pend_r    <= pend_nxt;
        mask_r    <= mask_nxt;
        fast_r    <= fast_nxt;
        cs_r      <= cs_nxt;
      end
      if (vec_we) begin
        vec_vld_r[vec_waddr] <= 1'b1;
      end
      if (oth_we) begin
        oth_vld_r[oth_waddr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register read, sees the state before this word's own update
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] rd_nxt;

  always_comb begin
    case (s1_word_r[6:5])
      2'b00:   rd_word = modes_r[s1_word_r[SRC_W-1:0]];
      2'b01:   rd_word = vec_a_eff;
      default: begin
        case (s1_word_r)
          W_IVR:  rd_word = irq_vec_cur;
          W_FVR:  rd_word = fiq_vec_r;
          W_ISR:  rd_word = cur_r;
          W_IPR:  rd_word = pend_r;
          W_IMR:  rd_word = mask_r;
          W_CISR: rd_word = {{(DATA_W-2){1'b0}}, cs_r};
          W_FFSR: rd_word = fast_r;
          // enable and disable words hold nothing
          W_IECR, W_IDCR, W_FFER, W_FFDR: rd_word = '0;
          default: rd_word = oth_eff;
        endcase
      end
    endcase
  end

  assign rd_nxt = is_rd ? rd_word : '0;

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] out_rdata_r;
  logic              out_irq_r;
  logic              out_fiq_r;
  logic              out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rdata_r <= rd_nxt;
      out_irq_r   <= cs_nxt[1];
      out_fiq_r   <= cs_nxt[0];
      out_err_r   <= acc_err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_read_data    = out_rdata_r;
  assign out_irq_line     = out_irq_r;
  assign out_fiq_line     = out_fiq_r;
  assign out_access_error = out_err_r;

endmodule

// ===== hw/rtl/vic_checker.sv =====
// vic_checker: port-level assertions for the vectored interrupt controller
// depends on vic_pkg; bound to vectored_interrupt_controller below
module vic_checker
  import vic_pkg::*;
#(
  parameter int REG_WORDS = 83
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_func,
  input logic [WORD_W-1:0] in_word_index,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_read_data,
  input logic              out_irq_line,
  input logic              out_fiq_line,
  input logic              out_access_error
);

  logic in_acc;
  logic in_event;
  logic in_bus_oob;

  assign in_acc     = in_valid && !in_stall;
  assign in_event   = (in_func == FUNC_RAISE) || (in_func == FUNC_LOWER);
  assign in_bus_oob = ((in_func == FUNC_READ) || (in_func == FUNC_WRITE)) &&
                      ({1'b0, in_word_index} >= 8'(REG_WORDS));

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
      $stable(out_irq_line) && $stable(out_fiq_line) && $stable(out_access_error))
    else $error("stalled result word changed");

  // a new result follows an accepted input word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result word without an accepted input word");

  // source events give no read data and no error
  a_event_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_event) ##1 (!out_valid || !out_stall) |=>
      out_valid && (out_read_data == '0) && !out_access_error)
    else $error("source event returned data or an error");

  // accesses beyond the map flag an error and read zero
  a_oob_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus_oob) ##1 (!out_valid || !out_stall) |=>
      out_valid && out_access_error && (out_read_data == '0))
    else $error("out-of-map access not flagged");

endmodule

bind vectored_interrupt_controller vic_checker #(
  .REG_WORDS (REG_WORDS)
) u_vic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_func          (in_func),
  .in_word_index    (in_word_index),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_read_data    (out_read_data),
  .out_irq_line     (out_irq_line),
  .out_fiq_line     (out_fiq_line),
  .out_access_error (out_access_error)
);

// ===== tb/vectored_interrupt_controller_tb.sv =====
`timescale 1ns / 1ps
// vectored_interrupt_controller_tb: self-checking bench for the 32-source interrupt controller
// drives register reads, writes and source events and checks every result word in order
// depends on vic_pkg and the vectored_interrupt_controller rtl
module vectored_interrupt_controller_tb;
  import vic_pkg::*;

  // map size the block is built with; words at or above it are out of range
  localparam int MAP_WORDS    = 83;
  localparam int PHASE_ITEMS  = 633;
  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // word indexes used by the directed table
  localparam logic [WORD_W-1:0] MODE_SRC0      = 7'd0;
  localparam logic [WORD_W-1:0] VEC_BASE       = 7'd32;
  localparam logic [WORD_W-1:0] VEC_SRC5       = 7'd37;
  localparam logic [WORD_W-1:0] PLAIN_WORD     = 7'd70;
  localparam logic [WORD_W-1:0] FIRST_UNMAPPED = 7'd83;
  localparam logic [WORD_W-1:0] TOP_WORD       = 7'd127;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
    logic              fiq_line;
    logic              access_error;
  } result_t;

  typedef struct {
    func_t             func;
    logic [WORD_W-1:0] word_index;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source_id;
  } access_t;

  typedef struct {
    func_t             func;
    logic [WORD_W-1:0] word_index;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source_id;
    bit                typed;
    result_t           fixed;
  } script_row_t;

  // fixed answers that need no prediction
  localparam result_t QUIET      = '{32'h0, 1'b0, 1'b0, 1'b0};
  localparam result_t OUT_OF_MAP = '{32'h0, 1'b0, 1'b0, 1'b1};

  // directed part: reset values, map edges, every function, every special word
  script_row_t script [25] = '{
    '{FUNC_READ,  W_CISR,         32'h0,        5'd0, 1'b1, QUIET},      // fresh out of reset
    '{FUNC_READ,  TOP_WORD,       32'h0,        5'd0, 1'b1, OUT_OF_MAP}, // last word, unmapped
    '{FUNC_WRITE, FIRST_UNMAPPED, 32'hffffffff, 5'd0, 1'b1, OUT_OF_MAP}, // dropped write
    '{FUNC_WRITE, VEC_BASE,       32'hffffffff, 5'd0, 1'b0, QUIET},      // fast vector source
    '{FUNC_WRITE, VEC_SRC5,       32'h12345678, 5'd0, 1'b0, QUIET},
    '{FUNC_WRITE, W_IECR,         32'hffffffff, 5'd0, 1'b0, QUIET},      // unmask everything
    '{FUNC_READ,  W_IECR,         32'h0,        5'd0, 1'b1, QUIET},      // enable word reads zero
    '{FUNC_READ,  W_IMR,          32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_RAISE, W_IVR,          32'h0,        5'd5, 1'b0, QUIET},      // normal line
    '{FUNC_READ,  W_IVR,          32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_READ,  W_ISR,          32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_RAISE, W_IVR,          32'h0,        5'd0, 1'b0, QUIET},      // source 0 goes fast
    '{FUNC_READ,  W_FVR,          32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_LOWER, W_IVR,          32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_WRITE, W_FFER,         32'h00000080, 5'd0, 1'b0, QUIET},      // force source 7 fast
    '{FUNC_RAISE, W_IVR,          32'h0,        5'd7, 1'b0, QUIET},
    '{FUNC_WRITE, W_FFDR,         32'hffffffff, 5'd0, 1'b0, QUIET},
    '{FUNC_WRITE, W_IMR,          32'h0,        5'd0, 1'b0, QUIET},      // read-only, ignored
    '{FUNC_WRITE, W_FFSR,         32'hffffffff, 5'd0, 1'b0, QUIET},      // read-only, ignored
    '{FUNC_WRITE, W_CISR,         32'hffffffff, 5'd0, 1'b0, QUIET},      // rebuilt at once
    '{FUNC_WRITE, W_IPR,          32'h80000000, 5'd0, 1'b0, QUIET},      // pending overwritten
    '{FUNC_WRITE, PLAIN_WORD,     32'hdeadbeef, 5'd0, 1'b0, QUIET},
    '{FUNC_READ,  PLAIN_WORD,     32'h0,        5'd0, 1'b0, QUIET},
    '{FUNC_WRITE, MODE_SRC0,      32'hffffffff, 5'd0, 1'b0, QUIET},
    '{FUNC_WRITE, W_IDCR,         32'hffffffff, 5'd0, 1'b0, QUIET}       // mask everything
  };

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func          = FUNC_READ;
  logic [WORD_W-1:0] in_word_index    = '0;
  logic [DATA_W-1:0] in_write_data    = '0;
  logic [SRC_W-1:0]  in_source_id     = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic              out_irq_line;
  logic              out_fiq_line;
  logic              out_access_error;

  // idling knobs, percent of cycles, changed per phase by the stimulus
  int      send_idle_pct = 16;
  int      stall_pct     = 87;
  bit      hold_request  = 1'b0;
  int      fault_count   = 0;
  int      quiet_cycles  = 0;
  result_t awaited_results [$];

  // shadow copy of the register map
  logic [DATA_W-1:0] mode_mem   [MAX_SRC];
  logic [DATA_W-1:0] vector_mem [MAX_SRC];
  logic [DATA_W-1:0] plain_mem  [64];
  logic [DATA_W-1:0] ivr_q, fvr_q, isr_q, ipr_q, imr_q, cisr_q, ffsr_q;

  vectored_interrupt_controller #(
    .NUM_SOURCES(MAX_SRC),
    .REG_WORDS  (MAP_WORDS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_word_index   (in_word_index),
    .in_write_data   (in_write_data),
    .in_source_id    (in_source_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_irq_line    (out_irq_line),
    .out_fiq_line    (out_fiq_line),
    .out_access_error(out_access_error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // applies one word to the shadow map, re-runs the priority encoder and
  // returns the result word the block must give for it
  function automatic result_t predict_word(access_t a);
    result_t           r;
    logic [DATA_W-1:0] active;
    bit                found;
    r = '0;
    case (a.func)
      FUNC_READ, FUNC_WRITE: begin
        if (int'(a.word_index) >= MAP_WORDS) begin
          r.access_error = 1'b1;
        end else if (a.func == FUNC_READ) begin
          if (a.word_index < VEC_BASE) begin
            r.read_data = mode_mem[a.word_index[4:0]];
          end else if (int'(a.word_index) < OTHER_BASE) begin
            r.read_data = vector_mem[a.word_index[4:0]];
          end else begin
            case (a.word_index)
              W_IVR:                         r.read_data = ivr_q;
              W_FVR:                         r.read_data = fvr_q;
              W_ISR:                         r.read_data = isr_q;
              W_IPR:                         r.read_data = ipr_q;
              W_IMR:                         r.read_data = imr_q;
              W_CISR:                        r.read_data = cisr_q;
              W_IECR, W_IDCR, W_FFER, W_FFDR: r.read_data = '0;
              W_FFSR:                        r.read_data = ffsr_q;
              default:                       r.read_data = plain_mem[a.word_index[5:0]];
            endcase
          end
        end else begin
          if (a.word_index < VEC_BASE) begin
            mode_mem[a.word_index[4:0]] = a.write_data;
          end else if (int'(a.word_index) < OTHER_BASE) begin
            vector_mem[a.word_index[4:0]] = a.write_data;
          end else begin
            case (a.word_index)
              W_IVR:          ivr_q = a.write_data;
              W_FVR:          fvr_q = a.write_data;
              W_ISR:          isr_q = a.write_data;
              W_IPR:          ipr_q = a.write_data;
              W_CISR:         cisr_q = a.write_data;
              W_IECR:         imr_q = imr_q | a.write_data;
              W_IDCR:         imr_q = imr_q & ~a.write_data;
              W_FFER:         ffsr_q = ffsr_q | a.write_data;
              W_FFDR:         ffsr_q = ffsr_q & ~a.write_data;
              W_IMR, W_FFSR:  ;
              default:        plain_mem[a.word_index[5:0]] = a.write_data;
            endcase
          end
        end
      end
      FUNC_RAISE: ipr_q[a.source_id] = 1'b1;
      default:    ipr_q[a.source_id] = 1'b0;
    endcase

    // fast side: source 0 or any forced source, lowest number wins
    active = ipr_q & imr_q;
    cisr_q = '0;
    found  = 1'b0;
    for (int i = 0; i < MAX_SRC; i++) begin
      if (!found && active[i] && (i == 0 || ffsr_q[i])) begin
        isr_q     = 32'(i);
        cisr_q[0] = 1'b1;
        fvr_q     = vector_mem[0];
        found     = 1'b1;
      end
    end
    // normal side: lowest unforced source above 0
    found = 1'b0;
    for (int i = 1; i < MAX_SRC; i++) begin
      if (!found && active[i] && !ffsr_q[i]) begin
        if (!cisr_q[0]) isr_q = 32'(i);
        cisr_q[1] = 1'b1;
        ivr_q     = vector_mem[i];
        found     = 1'b1;
      end
    end
    r.irq_line = cisr_q[1];
    r.fiq_line = cisr_q[0];
    return r;
  endfunction

  // offers one word, holds it until taken, then files its expected result
  task automatic offer(input access_t a, input bit typed, input result_t fixed);
    result_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= a.func;
    in_word_index <= a.word_index;
    in_write_data <= a.write_data;
    in_source_id  <= a.source_id;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = predict_word(a);
    awaited_results.push_back(typed ? fixed : guess);
  endtask

  // result side: checks each taken word, then decides the stall for the next cycle
  initial begin : receiver
    result_t want, got;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        got = {out_read_data, out_irq_line, out_fiq_line, out_access_error};
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("unexpected result word: rd=%h irq=%b fiq=%b err=%b",
                     got.read_data, got.irq_line, got.fiq_line, got.access_error);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data || got.irq_line !== want.irq_line ||
              got.fiq_line !== want.fiq_line || got.access_error !== want.access_error) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("mismatch: expected rd=%h irq=%b fiq=%b err=%b, got rd=%h irq=%b fiq=%b err=%b",
                       want.read_data, want.irq_line, want.fiq_line, want.access_error,
                       got.read_data, got.irq_line, got.fiq_line, got.access_error);
          end
        end
      end
      // a long hold-off lets the block fill up and push back on its input
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: too long without a word moving on either side ends the run
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    access_t a;
    int      pick, sel;
    foreach (mode_mem[i]) begin
      mode_mem[i]   = '0;
      vector_mem[i] = '0;
    end
    foreach (plain_mem[i]) plain_mem[i] = '0;
    {ivr_q, fvr_q, isr_q, ipr_q, imr_q, cisr_q, ffsr_q} = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, run under the first idling mix
    foreach (script[k]) begin
      a = '{script[k].func, script[k].word_index, script[k].write_data, script[k].source_id};
      offer(a, script[k].typed, script[k].fixed);
    end
    // sender pauses until every expected word is back
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);

    // random phases: receiver stalls more, then sender idles more, then neither
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 87 : 0;
      stall_pct     = (phase == 0) ? 87 : (phase == 1) ? 16 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 100) hold_request = 1'b1;
        pick         = $urandom_range(99);
        sel          = $urandom_range(99);
        a.source_id  = 5'($urandom_range(31));
        a.write_data = $urandom;
        // lean on the control words, keep a share of out-of-range indexes
        if (sel < 8)       a.word_index = 7'($urandom_range(127, MAP_WORDS));
        else if (sel < 45) a.word_index = 7'($urandom_range(MAP_WORDS - 1, OTHER_BASE));
        else if (sel < 65) a.word_index = 7'($urandom_range(OTHER_BASE - 1, 32));
        else if (sel < 80) a.word_index = 7'($urandom_range(31));
        else               a.word_index = 7'($urandom_range(127));
        if (pick < 25) begin
          a.func = FUNC_RAISE;
        end else if (pick < 40) begin
          a.func = FUNC_LOWER;
        end else if (pick < 70) begin
          a.func = FUNC_READ;
        end else begin
          a.func = FUNC_WRITE;
          // mask, fast set and pending words get single bits or all ones
          // more often, so the encoder sees sparse and full patterns
          if (a.word_index inside {W_IECR, W_IDCR, W_FFER, W_FFDR, W_IPR}) begin
            case ($urandom_range(3))
              0:       a.write_data = 32'h1 << $urandom_range(31);
              1:       a.write_data = '1;
              default: ;
            endcase
          end
        end
        offer(a, 1'b0, QUIET);
      end
      in_valid <= 1'b0;
      do @(posedge clk); while (awaited_results.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== vectored_interrupt_controller.f =====
hw/rtl/vic_pkg.sv
hw/rtl/vic_ram.sv
hw/rtl/vic_encode.sv
hw/rtl/vectored_interrupt_controller.sv
hw/rtl/vic_checker.sv
tb/vectored_interrupt_controller_tb.sv
